[hw/rtl/vsrd_pkg.sv]
`default_nettype none

package vsrd_pkg;

  // Parser phases of the record walk.
  typedef enum logic [2:0] {
    PH_WORD_LO,
    PH_WORD_HI,
    PH_OFFSET,
    PH_COMMON,
    PH_FULL,
    PH_POLY_HEAD,
    PH_POLY_VERT
  } phase_t;

  // Record type bytes.
  localparam logic [7:0] TYPE_OFFSET = 8'hFB;
  localparam logic [7:0] TYPE_COMMON = 8'hFE;
  localparam logic [7:0] TYPE_FILL   = 8'hFD;
  localparam logic [7:0] TYPE_COLOR  = 8'hFF;
  localparam logic [7:0] TYPE_END    = 8'hFC;
  localparam logic [7:0] TYPE_VECTOR_LIMIT = 8'h80;
  // Types from TYPE_VECTOR_LIMIT up to this one carry no drawing.
  localparam logic [7:0] TYPE_UNDEF_LAST = 8'hFA;
  localparam logic [7:0] COLOR_SEVEN = 8'd7;
  localparam logic [8:0] COLOR_NONE  = 9'h1FF;

  // Result kinds.
  localparam logic [1:0] KIND_LINE   = 2'd0;
  localparam logic [1:0] KIND_VERTEX = 2'd1;
  localparam logic [1:0] KIND_COLOR  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_LOW_FIRST  = 3'd0;
  localparam logic [2:0] REG_H_SCALE    = 3'd1;
  localparam logic [2:0] REG_V_SCALE    = 3'd2;
  localparam logic [2:0] REG_AREA_LEFT  = 3'd3;
  localparam logic [2:0] REG_AREA_TOP   = 3'd4;
  localparam logic [2:0] REG_AREA_HEIGHT = 3'd5;
  localparam logic [2:0] REG_DARK_BG    = 3'd6;

  localparam int ADDR_W     = 5;
  localparam int OUT_DATA_W = 144;

  typedef struct packed {
    logic        low_first;
    logic [31:0] h_scale;
    logic [31:0] v_scale;
    logic [15:0] area_left;
    logic [15:0] area_top;
    logic [15:0] area_height;
    logic        dark_background;
  } cfg_t;

  // Decoded record in slide units, before scaling.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] x_from;
    logic [15:0] y_from;
    logic [15:0] x_to;
    logic [15:0] y_to;
    logic [7:0]  color_index;
    logic        seven_white;
    logic        last_vertex;
  } rec_t;

endpackage

`default_nettype wire

[hw/rtl/vsrd_cfg.sv]
`default_nettype none

module vsrd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vsrd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output vsrd_pkg::cfg_t              cfg
);
  import vsrd_pkg::*;

  logic       wr;
  logic [2:0] index;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign index  = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_first       <= 1'b0;
      cfg.h_scale         <= 32'h0001_0000;
      cfg.v_scale         <= 32'h0001_0000;
      cfg.area_left       <= 16'h0000;
      cfg.area_top        <= 16'h0000;
      cfg.area_height     <= 16'h0000;
      cfg.dark_background <= 1'b1;
    end else if (wr) begin
      case (index)
        REG_LOW_FIRST:   cfg.low_first       <= pwdata[0];
        REG_H_SCALE:     cfg.h_scale         <= pwdata;
        REG_V_SCALE:     cfg.v_scale         <= pwdata;
        REG_AREA_LEFT:   cfg.area_left       <= pwdata[15:0];
        REG_AREA_TOP:    cfg.area_top        <= pwdata[15:0];
        REG_AREA_HEIGHT: cfg.area_height     <= pwdata[15:0];
        REG_DARK_BG:     cfg.dark_background <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_LOW_FIRST:   prdata = {31'h0, cfg.low_first};
      REG_H_SCALE:     prdata = cfg.h_scale;
      REG_V_SCALE:     prdata = cfg.v_scale;
      REG_AREA_LEFT:   prdata = {16'h0, cfg.area_left};
      REG_AREA_TOP:    prdata = {16'h0, cfg.area_top};
      REG_AREA_HEIGHT: prdata = {16'h0, cfg.area_height};
      REG_DARK_BG:     prdata = {31'h0, cfg.dark_background};
      default:         prdata = 32'h0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/vsrd_parser.sv]
`default_nettype none

module vsrd_parser #(
  parameter int MAX_VERTICES = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  vsrd_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           in_start,
  output logic           rec_valid,
  output vsrd_pkg::rec_t rec,
  input  logic           rec_ready
);
  import vsrd_pkg::*;

  localparam int LimW = $clog2(MAX_VERTICES + 1);

  phase_t          phase, phase_next, cur_phase;
  logic [2:0]      byte_count, byte_count_next, cur_count;
  logic [7:0]      record_bytes [8];
  logic [15:0]     last_x, last_y, last_x_next, last_y_next, cur_last_x, cur_last_y;
  logic [8:0]      prev_color, prev_color_next, cur_prev;
  logic [15:0]     vertices_left, vertices_left_next, cur_left;
  logic [15:0]     vertex_number, vertex_number_next, cur_number;
  logic [LimW-1:0] vertex_limit, vertex_limit_next;
  logic            accept, emit, wr_en;
  logic [2:0]      wr_index;
  logic [7:0]      hi_type, hi_op, stored_op;
  logic [15:0]     poly_count, count_m1, from_x, from_y;
  rec_t            rec_next;

  function automatic logic [15:0] add_off(input logic [15:0] base, input logic [7:0] off);
    return base + {{8{off[7]}}, off};
  endfunction

  assign in_ready = !rec_valid || rec_ready;
  assign accept   = in_valid && in_ready;

  // A start marker restarts the walk before this byte is used.
  assign cur_phase  = in_start ? PH_WORD_LO : phase;
  assign cur_count  = in_start ? 3'd0 : byte_count;
  assign cur_last_x = in_start ? 16'h0 : last_x;
  assign cur_last_y = in_start ? 16'h0 : last_y;
  assign cur_prev   = in_start ? COLOR_NONE : prev_color;
  assign cur_left   = in_start ? 16'h0 : vertices_left;
  assign cur_number = in_start ? 16'h0 : vertex_number;

  assign hi_type    = cfg.low_first ? record_bytes[0] : in_byte;
  assign hi_op      = cfg.low_first ? in_byte : record_bytes[0];
  assign stored_op  = cfg.low_first ? record_bytes[1] : record_bytes[0];
  assign poly_count = {record_bytes[3], record_bytes[2]};
  assign count_m1   = poly_count - 16'd1;

  always_comb begin
    phase_next      = cur_phase;
    byte_count_next = cur_count + 3'd1;
    case (cur_phase)
      PH_WORD_LO: begin
        phase_next      = PH_WORD_HI;
        byte_count_next = 3'd0;
      end
      PH_WORD_HI: begin
        byte_count_next = 3'd0;
        if (hi_type == TYPE_OFFSET) begin
          phase_next = PH_OFFSET;
        end else if (hi_type == TYPE_COMMON) begin
          phase_next = PH_COMMON;
        end else if (hi_type == TYPE_FILL) begin
          phase_next = PH_POLY_HEAD;
        end else if (hi_type < TYPE_VECTOR_LIMIT) begin
          phase_next = PH_FULL;
        end else begin
          phase_next = PH_WORD_LO;
        end
      end
      PH_OFFSET: begin
        if (cur_count == 3'd2) begin
          phase_next      = PH_WORD_LO;
          byte_count_next = 3'd0;
        end
      end
      PH_COMMON: begin
        phase_next      = PH_WORD_LO;
        byte_count_next = 3'd0;
      end
      PH_FULL: begin
        if (cur_count == 3'd5) begin
          phase_next      = PH_WORD_LO;
          byte_count_next = 3'd0;
        end
      end
      PH_POLY_HEAD: begin
        if (cur_count == 3'd3) begin
          byte_count_next = 3'd0;
          phase_next      = (poly_count != 16'h0) ? PH_POLY_VERT : PH_WORD_LO;
        end
      end
      PH_POLY_VERT: begin
        if (cur_count == 3'd5) begin
          byte_count_next = 3'd0;
          if (cur_left == 16'd1) begin
            phase_next = PH_WORD_LO;
          end
        end
      end
      default: begin
        phase_next      = PH_WORD_LO;
        byte_count_next = 3'd0;
      end
    endcase
  end

  always_comb begin
    wr_en              = 1'b1;
    wr_index           = 3'd2 + cur_count;
    emit               = 1'b0;
    rec_next           = '0;
    last_x_next        = cur_last_x;
    last_y_next        = cur_last_y;
    prev_color_next    = cur_prev;
    vertices_left_next = cur_left;
    vertex_number_next = cur_number;
    vertex_limit_next  = vertex_limit;
    from_x             = 16'h0;
    from_y             = 16'h0;
    case (cur_phase)
      PH_WORD_LO: begin
        wr_index = 3'd0;
      end
      PH_WORD_HI: begin
        wr_index = 3'd1;
        if (hi_type == TYPE_COLOR && {1'b0, hi_op} != cur_prev) begin
          emit                 = 1'b1;
          prev_color_next      = {1'b0, hi_op};
          rec_next.kind        = KIND_COLOR;
          rec_next.color_index = hi_op;
          rec_next.seven_white = (hi_op == COLOR_SEVEN) && cfg.dark_background;
        end
      end
      PH_OFFSET: begin
        if (cur_count == 3'd2) begin
          from_x          = add_off(cur_last_x, stored_op);
          from_y          = add_off(cur_last_y, record_bytes[2]);
          emit            = 1'b1;
          rec_next.kind   = KIND_LINE;
          rec_next.x_from = from_x;
          rec_next.y_from = from_y;
          rec_next.x_to   = add_off(cur_last_x, record_bytes[3]);
          rec_next.y_to   = add_off(cur_last_y, in_byte);
          last_x_next     = from_x;
          last_y_next     = from_y;
        end
      end
      PH_COMMON: begin
        wr_en           = 1'b0;
        emit            = 1'b1;
        rec_next.kind   = KIND_LINE;
        rec_next.x_from = cur_last_x;
        rec_next.y_from = cur_last_y;
        rec_next.x_to   = add_off(cur_last_x, stored_op);
        rec_next.y_to   = add_off(cur_last_y, in_byte);
        last_x_next     = rec_next.x_to;
        last_y_next     = rec_next.y_to;
      end
      PH_FULL: begin
        if (cur_count == 3'd5) begin
          emit            = 1'b1;
          rec_next.kind   = KIND_LINE;
          rec_next.x_from = {record_bytes[1], record_bytes[0]};
          rec_next.y_from = {record_bytes[3], record_bytes[2]};
          rec_next.x_to   = {record_bytes[5], record_bytes[4]};
          rec_next.y_to   = {in_byte, record_bytes[6]};
          last_x_next     = rec_next.x_from;
          last_y_next     = rec_next.y_from;
        end
      end
      PH_POLY_HEAD: begin
        if (cur_count == 3'd3) begin
          vertices_left_next = poly_count;
          vertex_number_next = 16'h0;
          // The final vertex is never drawn, and at most MAX_VERTICES are.
          if (poly_count == 16'h0) begin
            vertex_limit_next = '0;
          end else if (count_m1 > 16'(MAX_VERTICES)) begin
            vertex_limit_next = LimW'(MAX_VERTICES);
          end else begin
            vertex_limit_next = count_m1[LimW-1:0];
          end
        end
      end
      PH_POLY_VERT: begin
        if (cur_count == 3'd5) begin
          vertex_number_next = cur_number + 16'd1;
          vertices_left_next = cur_left - 16'd1;
          if (cur_number < 16'(vertex_limit)) begin
            emit                 = 1'b1;
            rec_next.kind        = KIND_VERTEX;
            rec_next.x_from      = {record_bytes[5], record_bytes[4]};
            rec_next.y_from      = {in_byte, record_bytes[6]};
            rec_next.last_vertex = (vertex_number_next == 16'(vertex_limit));
          end
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WORD_LO;
      byte_count    <= 3'd0;
      last_x        <= 16'h0;
      last_y        <= 16'h0;
      prev_color    <= COLOR_NONE;
      vertices_left <= 16'h0;
      vertex_number <= 16'h0;
      vertex_limit  <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      last_x        <= last_x_next;
      last_y        <= last_y_next;
      prev_color    <= prev_color_next;
      vertices_left <= vertices_left_next;
      vertex_number <= vertex_number_next;
      vertex_limit  <= vertex_limit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      record_bytes[wr_index] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (in_ready) begin
      rec_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      rec <= rec_next;
    end
  end

  a_rec_held: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_ready |=> rec_valid && $stable(rec))
    else $error("decoded record changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= 3'd5)
    else $error("byte count beyond a six-byte group");

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && in_start |=> phase == PH_WORD_HI)
    else $error("start marker did not restart the record walk");

  a_vertex_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_POLY_VERT |-> vertices_left != 16'h0)
    else $error("vertex phase with no vertices left");

endmodule

`default_nettype wire

[hw/rtl/vsrd_scale.sv]
`default_nettype none

module vsrd_scale (
  input  logic                            clk,
  input  logic                            rst,
  input  vsrd_pkg::cfg_t                  cfg,
  input  logic                            rec_valid,
  output logic                            rec_ready,
  input  vsrd_pkg::rec_t                  rec,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [vsrd_pkg::OUT_DATA_W-1:0] out_data,
  output logic [1:0]                      out_kind,
  output logic                            out_last
);
  import vsrd_pkg::*;

  localparam logic signed [33:0] QMax = 34'sd2147483647;
  localparam logic signed [33:0] QMin = -34'sd2147483648;

  logic [31:0] x_from, y_from, x_to, y_to;

  // Divide a Q16.16 value by 2^16 rounding toward zero, then clamp to 32 bits.
  function automatic logic [31:0] sat_q16(input logic signed [49:0] s);
    logic signed [33:0] q;
    q = 34'(s >>> 16);
    if (s[49] && s[15:0] != 16'h0) begin
      q = q + 34'sd1;
    end
    if (q > QMax) begin
      return 32'h7FFF_FFFF;
    end else if (q < QMin) begin
      return 32'h8000_0000;
    end
    return q[31:0];
  endfunction

  function automatic logic [31:0] map_x(input logic [15:0] c, input logic [31:0] h,
                                        input logic [15:0] left);
    logic [47:0]        p;
    logic signed [49:0] s;
    p = 48'(h) * 48'(c);
    s = $signed({2'b00, p}) + $signed({{18{left[15]}}, left, 16'h0000});
    return sat_q16(s);
  endfunction

  function automatic logic [31:0] map_y(input logic [15:0] c, input logic [31:0] v,
                                        input logic [15:0] top, input logic [15:0] height);
    logic [47:0]        p;
    logic signed [17:0] base;
    logic signed [49:0] s;
    p    = 48'(v) * 48'(c);
    base = $signed({2'b00, height}) + $signed({{2{top[15]}}, top});
    s    = $signed({{16{base[17]}}, base, 16'h0000}) - $signed({2'b00, p});
    return sat_q16(s);
  endfunction

  assign rec_ready = !out_valid || out_ready;

  always_comb begin
    x_from = map_x(rec.x_from, cfg.h_scale, cfg.area_left);
    y_from = map_y(rec.y_from, cfg.v_scale, cfg.area_top, cfg.area_height);
    x_to   = map_x(rec.x_to, cfg.h_scale, cfg.area_left);
    y_to   = map_y(rec.y_to, cfg.v_scale, cfg.area_top, cfg.area_height);
    // Only a line segment carries an end point; a colour change has no points.
    if (rec.kind != KIND_LINE) begin
      x_to = 32'h0;
      y_to = 32'h0;
    end
    if (rec.kind == KIND_COLOR) begin
      x_from = 32'h0;
      y_from = 32'h0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_ready) begin
      out_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && rec_ready) begin
      out_data <= {7'h00, rec.seven_white, rec.color_index, y_to, x_to, y_from, x_from};
      out_kind <= rec.kind;
      out_last <= rec.last_vertex;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/vector_slide_record_decoder_core.sv]
// Vector slide record decoder.
// The slave stream takes the slide body one byte per request; s_tuser set on
// a byte restarts the parser, forgets the last point and the last colour, and
// takes that byte as the first byte of a new body.
// The master stream gives one request per drawn item: a line segment, a
// polygon vertex (m_tlast on the final vertex drawn) or a colour change.
// Coordinates leave scaled by the Q16.16 factors, moved to the drawing area,
// with y flipped, rounded toward zero and clamped to 32 bits.
// The APB port holds the scale, area and colour settings; write it only while
// no byte is in flight.
// Throughput is one byte per cycle while m_tready is high. The byte that
// completes a record is decoded into the record register at the edge that
// accepts it; the scaling multipliers work on it combinationally and load the
// output register, which raises m_tvalid.
// When the receiver stalls, the output register and the record register hold
// their contents; s_tready falls only once both are full.
// Reset (synchronous) returns the parser to the start of a record word, clears
// the last point, forgets the last colour and loads the default settings.
`default_nettype none

module vector_slide_record_decoder_core #(
  parameter int MAX_VERTICES = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] data_byte
  input  logic                            s_tuser,   // [0] stream_start
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [31:0] x_from, [63:32] y_from, [95:64] x_to, [127:96] y_to,
  // [135:128] color_index, [136] seven_white, [143:137] zero
  output logic [vsrd_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]                      m_tuser,   // [1:0] kind
  output logic                            m_tlast,   // last_vertex
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vsrd_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import vsrd_pkg::*;

  cfg_t cfg;
  rec_t rec;
  logic rec_valid;
  logic rec_ready;

  vsrd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vsrd_parser #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_start  (s_tuser),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_ready (rec_ready)
  );

  vsrd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_kind  (m_tuser),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
  import vsrd_pkg::*;

  localparam int MAX_VERT = 10;
  localparam int WATCHDOG = 2000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] x_from;
    logic [31:0] y_from;
    logic [31:0] x_to;
    logic [31:0] y_to;
    logic [7:0]  colour;
    logic        seven;
    logic        last;
  } draw_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;      // [7:0] data_byte
  logic s_tuser = 1'b0;          // [0] stream_start
  logic m_tvalid;
  logic m_tready = 1'b0;
  // [31:0] x_from, [63:32] y_from, [95:64] x_to, [127:96] y_to,
  // [135:128] color_index, [136] seven_white, [143:137] zero
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;           // [1:0] kind
  logic m_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  vector_slide_record_decoder_core #(.MAX_VERTICES(MAX_VERT)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the register settings.
  logic        lf_q = 1'b0;
  logic [31:0] hs_q = 32'h0001_0000;
  logic [31:0] vs_q = 32'h0001_0000;
  logic [15:0] al_q = '0;
  logic [15:0] at_q = '0;
  logic [15:0] ah_q = '0;
  logic        dk_q = 1'b1;

  // Shadow of the record walk.
  phase_t      walk;
  logic [3:0]  nbytes;
  logic [7:0]  rec_buf [8];
  logic [15:0] px, py;
  logic [8:0]  last_colour;
  logic [15:0] fill_left, fill_no;

  draw_t pending [$];
  int    errors = 0;
  int    bytes_in = 0;
  int    settings = 1;
  int    lines_seen = 0, vertices_seen = 0, colours_seen = 0;
  int    quiet = 0;
  bit    calm = 1'b0;
  bit    resync = 1'b0;
  logic [7:0] recent_colour = '0;

  function automatic void restart_walk();
    walk = PH_WORD_LO;
    nbytes = '0;
    for (int i = 0; i < 8; i++) rec_buf[i] = '0;
    px = '0;
    py = '0;
    last_colour = COLOR_NONE;
    fill_left = '0;
    fill_no = '0;
  endfunction

  function automatic logic [31:0] clamp_q16(longint s);
    longint q;
    q = s / 65536;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic logic [31:0] scale_x(logic [15:0] c);
    longint h, cc, left;
    h = 64'(hs_q);
    cc = 64'(c);
    left = 64'($signed(al_q));
    return clamp_q16(h * cc + left * 65536);
  endfunction

  function automatic logic [31:0] scale_y(logic [15:0] c);
    longint v, cc, ht, tp;
    v = 64'(vs_q);
    cc = 64'(c);
    ht = 64'(ah_q);
    tp = 64'($signed(at_q));
    return clamp_q16((ht + tp) * 65536 - v * cc);
  endfunction

  function automatic logic [15:0] nudge(logic [15:0] base, logic [7:0] off);
    return base + {{8{off[7]}}, off};
  endfunction

  function automatic logic [15:0] buf_word(int i);
    return {rec_buf[3'(i + 1)], rec_buf[3'(i)]};
  endfunction

  function automatic draw_t segment(logic [15:0] fx, fy, tx, ty);
    draw_t d;
    d = '0;
    d.kind = KIND_LINE;
    d.x_from = scale_x(fx);
    d.y_from = scale_y(fy);
    d.x_to = scale_x(tx);
    d.y_to = scale_y(ty);
    return d;
  endfunction

  // Advances the shadow walk by one byte and queues the result it draws, if any.
  function automatic void decode_byte(logic [7:0] b, logic start);
    draw_t d;
    logic [7:0] kind_b, opnd;
    logic [15:0] fx, fy, tx, ty, total, lim;
    if (start) restart_walk();
    d = '0;
    opnd = lf_q ? rec_buf[1] : rec_buf[0];
    case (walk)
      PH_WORD_HI: begin
        rec_buf[1] = b;
        nbytes = '0;
        walk = PH_WORD_LO;
        kind_b = lf_q ? rec_buf[0] : b;
        opnd = lf_q ? b : rec_buf[0];
        if (kind_b == TYPE_OFFSET) walk = PH_OFFSET;
        else if (kind_b == TYPE_COMMON) walk = PH_COMMON;
        else if (kind_b == TYPE_FILL) walk = PH_POLY_HEAD;
        else if (kind_b == TYPE_COLOR) begin
          if ({1'b0, opnd} != last_colour) begin
            last_colour = {1'b0, opnd};
            d.kind = KIND_COLOR;
            d.colour = opnd;
            d.seven = (opnd == COLOR_SEVEN) ? dk_q : 1'b0;
            pending.push_back(d);
          end
        end else if (kind_b < TYPE_VECTOR_LIMIT) walk = PH_FULL;
      end
      PH_OFFSET: begin
        rec_buf[3'(nbytes + 4'd2)] = b;
        nbytes++;
        if (nbytes == 4'd3) begin
          fx = nudge(px, opnd);
          fy = nudge(py, rec_buf[2]);
          tx = nudge(px, rec_buf[3]);
          ty = nudge(py, rec_buf[4]);
          pending.push_back(segment(fx, fy, tx, ty));
          px = fx;
          py = fy;
          walk = PH_WORD_LO;
          nbytes = '0;
        end
      end
      PH_COMMON: begin
        tx = nudge(px, opnd);
        ty = nudge(py, b);
        pending.push_back(segment(px, py, tx, ty));
        px = tx;
        py = ty;
        walk = PH_WORD_LO;
        nbytes = '0;
      end
      PH_FULL: begin
        rec_buf[3'(nbytes + 4'd2)] = b;
        nbytes++;
        if (nbytes == 4'd6) begin
          fx = buf_word(0);
          fy = buf_word(2);
          pending.push_back(segment(fx, fy, buf_word(4), buf_word(6)));
          px = fx;
          py = fy;
          walk = PH_WORD_LO;
          nbytes = '0;
        end
      end
      PH_POLY_HEAD: begin
        rec_buf[3'(nbytes + 4'd2)] = b;
        nbytes++;
        if (nbytes == 4'd4) begin
          nbytes = '0;
          fill_left = buf_word(2);
          fill_no = '0;
          walk = (fill_left != 0) ? PH_POLY_VERT : PH_WORD_LO;
        end
      end
      PH_POLY_VERT: begin
        rec_buf[3'(nbytes + 4'd2)] = b;
        nbytes++;
        if (nbytes == 4'd6) begin
          nbytes = '0;
          // The last vertex of the count is never drawn, and no more than
          // MAX_VERT vertices are drawn at all.
          total = fill_no + fill_left;
          lim = (total != 0) ? total - 16'd1 : 16'd0;
          if (lim > MAX_VERT) lim = 16'(MAX_VERT);
          if (fill_no < lim) begin
            d.kind = KIND_VERTEX;
            d.x_from = scale_x(buf_word(4));
            d.y_from = scale_y(buf_word(6));
            d.last = (fill_no == lim - 16'd1);
            pending.push_back(d);
          end
          fill_no = fill_no + 16'd1;
          fill_left = fill_left - 16'd1;
          if (fill_left == 0) walk = PH_WORD_LO;
        end
      end
      default: begin
        rec_buf[0] = b;
        nbytes = '0;
        walk = PH_WORD_HI;
      end
    endcase
  endfunction

  // One request per byte; its results are predicted at the edge that takes it.
  task automatic send_byte(input logic [7:0] b, input logic start);
    if (!calm && $urandom_range(99) < 23) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 23);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= start;
    do @(posedge clk); while (!s_tready);
    decode_byte(b, start);
    bytes_in++;
  endtask

  task automatic send_word(input logic [7:0] kind_b, input logic [7:0] opnd,
                           input logic start);
    if (lf_q) begin
      send_byte(kind_b, start);
      send_byte(opnd, 1'b0);
    end else begin
      send_byte(opnd, start);
      send_byte(kind_b, 1'b0);
    end
  endtask

  task automatic full_vector(input logic [15:0] fx, fy, tx, ty, input logic start);
    send_byte(fx[7:0], start);
    send_byte(fx[15:8], 1'b0);
    send_byte(fy[7:0], 1'b0);
    send_byte(fy[15:8], 1'b0);
    send_byte(tx[7:0], 1'b0);
    send_byte(tx[15:8], 1'b0);
    send_byte(ty[7:0], 1'b0);
    send_byte(ty[15:8], 1'b0);
  endtask

  task automatic offset_vector(input logic [7:0] o0, o1, o2, o3, input logic start);
    send_word(TYPE_OFFSET, o0, start);
    send_byte(o1, 1'b0);
    send_byte(o2, 1'b0);
    send_byte(o3, 1'b0);
  endtask

  task automatic common_end(input logic [7:0] o0, o1, input logic start);
    send_word(TYPE_COMMON, o0, start);
    send_byte(o1, 1'b0);
  endtask

  task automatic colour_rec(input logic [7:0] c, input logic start);
    send_word(TYPE_COLOR, c, start);
    recent_colour = c;
  endtask

  task automatic solid_fill(input logic [15:0] count, input logic start);
    send_word(TYPE_FILL, 8'($urandom), start);
    send_byte(count[7:0], 1'b0);
    send_byte(count[15:8], 1'b0);
    repeat (2) send_byte(8'($urandom), 1'b0);
    repeat (count) repeat (6) send_byte(8'($urandom), 1'b0);
  endtask

  // Stops the stream, waits for every outstanding result and lets the
  // pipeline run empty.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_LOW_FIRST:   lf_q = val[0];
      REG_H_SCALE:     hs_q = val;
      REG_V_SCALE:     vs_q = val;
      REG_AREA_LEFT:   al_q = val[15:0];
      REG_AREA_TOP:    at_q = val[15:0];
      REG_AREA_HEIGHT: ah_q = val[15:0];
      REG_DARK_BG:     dk_q = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic lf, input logic [31:0] hs, vs,
                            input logic [15:0] al, at, ah, input logic dk);
    drain();
    write_reg(REG_LOW_FIRST, {31'b0, lf});
    write_reg(REG_H_SCALE, hs);
    write_reg(REG_V_SCALE, vs);
    write_reg(REG_AREA_LEFT, {16'b0, al});
    write_reg(REG_AREA_TOP, {16'b0, at});
    write_reg(REG_AREA_HEIGHT, {16'b0, ah});
    write_reg(REG_DARK_BG, {31'b0, dk});
    settings++;
  endtask

  task automatic test_line_records();
    full_vector(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1);
    full_vector(16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF, 1'b0);
    // Offsets are signed bytes, so these step both ways from the last point.
    offset_vector(8'h80, 8'h7F, 8'hFF, 8'h01, 1'b0);
    common_end(8'h80, 8'h7F, 1'b0);
  endtask

  task automatic test_colour_records();
    colour_rec(COLOR_SEVEN, 1'b1);
    colour_rec(COLOR_SEVEN, 1'b0);
    colour_rec(8'h00, 1'b0);
    colour_rec(8'hFF, 1'b0);
    send_word(TYPE_END, 8'h55, 1'b0);
    send_word(TYPE_VECTOR_LIMIT, 8'hAA, 1'b0);
    send_word(TYPE_UNDEF_LAST, 8'h00, 1'b0);
  endtask

  task automatic test_solid_fills();
    solid_fill(16'd0, 1'b1);
    solid_fill(16'd1, 1'b0);
    solid_fill(16'd3, 1'b0);
  endtask

  task automatic test_restart();
    // A record cut short by a fresh start must leave nothing behind.
    send_word(TYPE_OFFSET, 8'h10, 1'b0);
    send_byte(8'h05, 1'b0);
    common_end(8'h03, 8'hFD, 1'b1);
  endtask

  task automatic random_record();
    logic [15:0] w;
    logic [7:0] c;
    int pick;
    logic st;
    st = resync || ($urandom_range(39) == 0);
    resync = 1'b0;
    pick = $urandom_range(99);
    if (pick < 22) begin
      w = 16'($urandom);
      if (lf_q) w[7] = 1'b0;
      else w[15] = 1'b0;
      full_vector(w, 16'($urandom), 16'($urandom), 16'($urandom), st);
    end else if (pick < 40) begin
      offset_vector(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), st);
    end else if (pick < 55) begin
      common_end(8'($urandom), 8'($urandom), st);
    end else if (pick < 68) begin
      solid_fill(16'(($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(13)),
                 st);
    end else if (pick < 84) begin
      case ($urandom_range(3))
        0: c = COLOR_SEVEN;
        1: c = recent_colour;
        default: c = 8'($urandom);
      endcase
      colour_rec(c, st);
    end else if (pick < 92) begin
      send_word((pick < 88) ? TYPE_END :
                8'($urandom_range(32'(TYPE_VECTOR_LIMIT), 32'(TYPE_UNDEF_LAST))),
                8'($urandom), st);
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(15) == 0);
      resync = 1'b1;
    end
  endtask

  task automatic test_random_phase(input int n);
    int goal, half;
    bit paused;
    goal = bytes_in + n;
    half = bytes_in + n / 2;
    paused = 1'b0;
    resync = 1'b1;
    while (bytes_in < goal) begin
      random_record();
      if (!paused && bytes_in >= half) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  task automatic compare_field(input string what, input logic [31:0] want_v, got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) m_tready <= calm || ($urandom_range(99) >= 23);

  always @(posedge clk) begin : check_results
    draw_t want;
    if (m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, kind %0h data %h", $time, m_tuser, m_tdata);
        errors++;
      end else begin
        want = pending.pop_front();
        compare_field("kind", 32'(want.kind), 32'(m_tuser));
        compare_field("x_from", want.x_from, m_tdata[31:0]);
        compare_field("y_from", want.y_from, m_tdata[63:32]);
        compare_field("x_to", want.x_to, m_tdata[95:64]);
        compare_field("y_to", want.y_to, m_tdata[127:96]);
        compare_field("color_index", 32'(want.colour), 32'(m_tdata[135:128]));
        compare_field("seven_white", 32'(want.seven), 32'(m_tdata[136]));
        compare_field("padding", 32'd0, 32'(m_tdata[143:137]));
        compare_field("last_vertex", 32'(want.last), 32'(m_tlast));
        case (want.kind)
          KIND_LINE:   lines_seen++;
          KIND_VERTEX: vertices_seen++;
          default:     colours_seen++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG);
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    restart_walk();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_line_records();
    test_colour_records();
    test_solid_fills();
    test_restart();
    test_random_phase(275);
    set_config(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0);
    test_random_phase(275);
    calm = 1'b1;
    set_config(1'b0, 32'h0, 32'h0, 16'h7FFF, 16'h8000, 16'h0000, 1'b1);
    test_random_phase(275);
    calm = 1'b0;
    set_config(1'b1, 32'h0001_8000, 32'h0000_C000, 16'($urandom), 16'($urandom),
               16'($urandom), 1'b1);
    test_random_phase(275);
    set_config(1'b0, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
               1'($urandom_range(1)));
    test_random_phase(275);
    drain();
    $display("Sent %0d body bytes under %0d register settings, with restarts and noise.",
             bytes_in, settings);
    $display("Checked %0d line segments, %0d polygon vertices and %0d colour changes.",
             lines_seen, vertices_seen, colours_seen);
    if (errors == 0 && pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
